// ----- rtl/cfpb_pkg.sv -----
// Shared constants and types for the CRC framed packet builder.
`default_nettype none

package cfpb_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned CRC_W      = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned MAX_WORDS  = 7;
    localparam int unsigned CNT_W      = 3;

    localparam logic [CRC_W-1:0] CRC_SEED = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h03;

    // Input commands.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 1'b1;

    // Word counts of the possible result runs.
    localparam logic [CNT_W-1:0] CNT_NONE       = 3'd0;
    localparam logic [CNT_W-1:0] CNT_DATA       = 3'd1;
    localparam logic [CNT_W-1:0] CNT_HEADER     = 3'd4;
    localparam logic [CNT_W-1:0] CNT_DATA_TRAIL = 3'd4;
    localparam logic [CNT_W-1:0] CNT_FULL_FRAME = 3'd7;

    // One run of result words, first word in entry 0.
    typedef struct packed {
        logic                              load;
        logic [MAX_WORDS-1:0][BYTE_W-1:0]  words;
        logic [CNT_W-1:0]                  cnt;
        logic                              trail;
    } t_load;

endpackage

`default_nettype wire

// ----- rtl/cfpb_crc16.sv -----
// CRC-16/CCITT update of a running value by one byte, MSB first.
`default_nettype none

module cfpb_crc16 (
    input  wire logic [cfpb_pkg::CRC_W-1:0]  i_crc,
    input  wire logic [cfpb_pkg::BYTE_W-1:0] i_byte,
    output logic      [cfpb_pkg::CRC_W-1:0]  o_crc
);

    always_comb begin
        logic [cfpb_pkg::CRC_W-1:0] c;
        c = i_crc ^ {i_byte, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[cfpb_pkg::CRC_W-1]) begin
                c = {c[cfpb_pkg::CRC_W-2:0], 1'b0} ^ cfpb_pkg::CRC_POLY;
            end else begin
                c = {c[cfpb_pkg::CRC_W-2:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

`default_nettype wire

// ----- rtl/cfpb_out_buf.sv -----
// Result register handing a run of up to seven words out one per unstalled cycle.
`default_nettype none

module cfpb_out_buf (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cfpb_pkg::t_load               i_load,
    output logic                               o_ready,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [cfpb_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                               o_run_last,
    output logic                               o_frame_end
);

    logic [cfpb_pkg::MAX_WORDS-1:0][cfpb_pkg::BYTE_W-1:0] r_words, n_words;
    logic [cfpb_pkg::CNT_W-1:0]                           r_left, n_left;
    logic                                                 r_trail, n_trail;
    logic                                                 pop;
    logic                                                 last;

    assign last = (r_left == cfpb_pkg::CNT_DATA);
    assign pop  = (r_left != cfpb_pkg::CNT_NONE) && !i_out_stall;

    // A new run may enter when the buffer is empty or its last word leaves now.
    assign o_ready = (r_left == cfpb_pkg::CNT_NONE) || (pop && last);

    always_comb begin
        n_words = r_words;
        n_left  = r_left;
        n_trail = r_trail;
        if (pop) begin
            n_words = {{cfpb_pkg::BYTE_W{1'b0}}, r_words[cfpb_pkg::MAX_WORDS-1:1]};
            n_left  = r_left - cfpb_pkg::CNT_DATA;
        end
        if (i_load.load && o_ready) begin
            n_words = i_load.words;
            n_left  = i_load.cnt;
            n_trail = i_load.trail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= cfpb_pkg::CNT_NONE;
        end else begin
            r_left <= n_left;
        end
        r_words <= n_words;
        r_trail <= n_trail;
    end

    assign o_out_valid = (r_left != cfpb_pkg::CNT_NONE);
    assign o_out_byte  = r_words[0];
    assign o_run_last  = last;
    assign o_frame_end = last && r_trail;

endmodule

`default_nettype wire

// ----- rtl/crc_framed_packet_builder_top.sv -----
// Top level of the CRC framed packet builder.
`default_nettype none

// Builds serial frames: start marker, 16-bit little-endian length (payload
// size plus one), type byte, payload bytes, CRC-16/CCITT (poly 0x1021, seed
// 0xFFFF, over type and payload) low then high byte, and end marker. A start
// word (cmd 0) yields four output words, or all seven when the payload length
// is zero; a payload word (cmd 1) yields one output word, or four when it is
// the last of the frame. A payload word outside a frame is dropped and a new
// start abandons the open frame. The CRC byte update is one combinational
// stage, so an input word is taken in any cycle in which the output buffer is
// empty or sends its last word. A word that yields output words holds the
// input until its last output word leaves, a dropped payload word produces
// no output, and a streaming payload byte goes through at one per cycle
// while the output does not stall. The first output word appears the cycle
// after its input word is taken, and the input stall follows the output stall
// in the same cycle. No clearing pass follows reset. Registers 0 and 1 set
// the start and end markers.

module crc_framed_packet_builder_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [cfpb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [cfpb_pkg::BYTE_W-1:0]        i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_cmd,
    input  wire logic [cfpb_pkg::BYTE_W-1:0]        i_frame_type,
    input  wire logic [cfpb_pkg::LEN_W-1:0]         i_payload_len,
    input  wire logic [cfpb_pkg::BYTE_W-1:0]        i_data_byte,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic      [cfpb_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                                    o_run_last,
    output logic                                    o_frame_end
);

    logic [cfpb_pkg::BYTE_W-1:0] r_start_marker;
    logic [cfpb_pkg::BYTE_W-1:0] r_end_marker;
    logic [cfpb_pkg::CRC_W-1:0]  r_crc, n_crc;
    logic [cfpb_pkg::LEN_W-1:0]  r_left, n_left;
    logic                        r_in_frame, n_in_frame;

    logic                        ready;
    logic                        accept;
    logic [cfpb_pkg::CRC_W-1:0]  crc_in;
    logic [cfpb_pkg::BYTE_W-1:0] crc_byte;
    logic [cfpb_pkg::CRC_W-1:0]  crc_out;
    logic [cfpb_pkg::LEN_W-1:0]  len_field;
    logic [cfpb_pkg::LEN_W-1:0]  left_dec;
    cfpb_pkg::t_load             load;

    assign accept     = i_in_valid && ready;
    assign o_in_stall = !ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= cfpb_pkg::START_MARKER_RST;
            r_end_marker   <= cfpb_pkg::END_MARKER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cfpb_pkg::REG_START_MARKER: r_start_marker <= i_cfg_data;
                cfpb_pkg::REG_END_MARKER:   r_end_marker   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A start word restarts the CRC from its seed with the type byte.
    assign crc_in   = (i_cmd == cfpb_pkg::CMD_START) ? cfpb_pkg::CRC_SEED : r_crc;
    assign crc_byte = (i_cmd == cfpb_pkg::CMD_START) ? i_frame_type : i_data_byte;

    cfpb_crc16 u_crc (
        .i_crc  (crc_in),
        .i_byte (crc_byte),
        .o_crc  (crc_out)
    );

    assign len_field = i_payload_len + cfpb_pkg::LEN_W'(1);
    assign left_dec  = r_left - cfpb_pkg::LEN_W'(1);

    always_comb begin
        n_crc      = r_crc;
        n_left     = r_left;
        n_in_frame = r_in_frame;
        load.load  = 1'b0;
        load.words = '0;
        load.cnt   = cfpb_pkg::CNT_NONE;
        load.trail = 1'b0;
        if (i_cmd == cfpb_pkg::CMD_START) begin
            n_crc      = crc_out;
            n_left     = i_payload_len;
            n_in_frame = (i_payload_len != '0);
            load.load  = 1'b1;
            load.words = {r_end_marker, crc_out[15:8], crc_out[7:0], i_frame_type,
                          len_field[15:8], len_field[7:0], r_start_marker};
            if (i_payload_len == '0) begin
                load.cnt   = cfpb_pkg::CNT_FULL_FRAME;
                load.trail = 1'b1;
            end else begin
                load.cnt   = cfpb_pkg::CNT_HEADER;
            end
        end else if (r_in_frame) begin
            n_crc      = crc_out;
            n_left     = left_dec;
            n_in_frame = (left_dec != '0);
            load.load  = 1'b1;
            load.words = {24'h000000, r_end_marker, crc_out[15:8], crc_out[7:0],
                          i_data_byte};
            if (left_dec == '0) begin
                load.cnt   = cfpb_pkg::CNT_DATA_TRAIL;
                load.trail = 1'b1;
            end else begin
                load.cnt   = cfpb_pkg::CNT_DATA;
            end
        end
        if (!accept) begin
            load.load = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= cfpb_pkg::CRC_SEED;
            r_left     <= '0;
            r_in_frame <= 1'b0;
        end else if (accept) begin
            r_crc      <= n_crc;
            r_left     <= n_left;
            r_in_frame <= n_in_frame;
        end
    end

    cfpb_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .o_ready     (ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_frame_end (o_frame_end)
    );

endmodule

`default_nettype wire
